// ----- rtl/lock_allocator_with_hold_stats_unit_defines.svh -----
// Assertion macros used by the lock allocator top level.
`ifndef LOCK_ALLOCATOR_WITH_HOLD_STATS_UNIT_DEFINES_SVH
`define LOCK_ALLOCATOR_WITH_HOLD_STATS_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LA_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define LA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ----- rtl/lahs_pkg.sv -----
// Package with types and codes of the lock allocator.
package lahs_pkg;
  typedef enum logic [3:0] {
    K_ALLOC = 4'd0, K_REG = 4'd1, K_FREE = 4'd2, K_ACQ = 4'd3, K_REL = 4'd4,
    K_READ = 4'd5, K_CNTCAT = 4'd6, K_CNTALL = 4'd7, K_RELTASK = 4'd8
  } kind_t;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ARG = 3'd1;
  localparam logic [2:0] ST_ALREADY = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_NONE_FREE = 3'd4;
  localparam logic [2:0] ST_RESERVED = 3'd5;
  localparam logic [3:0] CAT_SCHED = 4'd1;
  localparam logic [1:0] ADDR_ENABLED = 2'd0;
  localparam logic [1:0] ADDR_RESERVED = 2'd1;
  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_RD, S_SCAN, S_WB, S_OUT
  } state_t;
  typedef struct packed {
    logic [3:0]  category;
    logic [31:0] owner;
    logic [31:0] acquires;
    logic [63:0] total_held;
    logic [63:0] max_held;
    logic [63:0] last_acquire;
  } entry_t;
endpackage

// ----- rtl/lock_allocator_with_hold_stats_unit.sv -----
// Top level of the lock allocator with hold statistics.
// Usage: a request transaction enters on in_valid/in_ready with its kind,
// lock index, category, task and timestamp. Exactly one result transaction
// leaves on out_valid/out_ready carrying a status and, for reads, the entry.
// Two configuration registers sit on the cfg_ APB port: enabled at byte 0
// and reserved_lock at byte 4; pready is always high and reads return values.
// Entry state lives in one synchronous memory of NUM_LOCKS wide words; the
// allocated marks live in a flip-flop vector so allocate finds a free lock
// combinationally. A single-entry request passes through a read (address,
// then registered data) and a write back before out_valid rises.
// A request rejected by the early checks goes from the read state straight
// to the output state, which raises out_valid. Count and release-by-task
// requests walk every entry through the memory port before out_valid rises,
// and each ownership that a release-by-task clears holds back the next read.
// After reset the block sweeps the memory once to clear it, and accepts no
// request during that time.
// One request is in flight at a time, and the block returns to idle after
// each taken result before it accepts the next request.
// While the receiver stalls the result is held and nothing new is accepted.
module lock_allocator_with_hold_stats_unit import lahs_pkg::*; #(
  parameter int NUM_LOCKS = 32,
  parameter int NUM_CATEGORIES = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [5:0]  in_lock_index,
  input  logic [3:0]  in_category_in,
  input  logic [31:0] in_task_id,
  input  logic [63:0] in_timestamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_granted_lock,
  output logic [5:0]  out_count_out,
  output logic        out_entry_allocated,
  output logic [3:0]  out_entry_category,
  output logic [31:0] out_entry_owner,
  output logic [31:0] out_entry_acquires,
  output logic [63:0] out_entry_total_held,
  output logic [63:0] out_entry_max_held,
  output logic [63:0] out_entry_last_acquire,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
`include "lock_allocator_with_hold_stats_unit_defines.svh"
  localparam int AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  // Configuration registers.
  logic       enabled_r;
  logic [4:0] reserved_r;
  logic [1:0] cfg_word;
  assign cfg_word = cfg_paddr[2] ? ADDR_RESERVED : ADDR_ENABLED;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      reserved_r <= 5'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_word == ADDR_ENABLED) enabled_r <= cfg_pwdata[0];
      else reserved_r <= cfg_pwdata[4:0];
    end
  end
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[1:0] == 2'd0) begin
      if (cfg_word == ADDR_ENABLED) cfg_prdata = {31'd0, enabled_r};
      else cfg_prdata = {27'd0, reserved_r};
    end
  end

  // The reserved entry counts only when its index lies inside the table.
  logic          res_valid;
  logic [AW-1:0] res_idx;
  assign res_valid = ({27'd0, reserved_r} < NUM_LOCKS);
  assign res_idx   = reserved_r[AW-1:0];

  // Request registers.
  logic [3:0]  kind_r;
  logic [5:0]  idx_r;
  logic [3:0]  cat_r;
  logic [31:0] task_r;
  logic [63:0] ts_r;

  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW:0]   clr_r;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          rd_wait_r, rd_wait_nxt;
  logic [NUM_LOCKS-1:0] map_r, map_nxt;

  logic   ram_we;
  entry_t ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr;

  lahs_entry_ram #(.DEPTH(NUM_LOCKS), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Effective allocated mark as a vector, the reserved bit forced high.
  logic [NUM_LOCKS-1:0] eff_map;
  always_comb begin
    eff_map = map_r;
    if (res_valid) eff_map[res_idx] = 1'b1;
  end

  // Lowest free entry.
  logic          free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!eff_map[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // Checks that need no memory data.
  logic in_range, cur_alloc, cur_res, cat_ok_alloc;
  assign in_range  = ({26'd0, idx_r} < NUM_LOCKS);
  assign cur_alloc = eff_map[addr_r];
  assign cur_res   = res_valid && (addr_r == res_idx);
  assign cat_ok_alloc = (cat_r != 4'd0) && ({28'd0, cat_r} < NUM_CATEGORIES);

  logic [2:0] early_st;
  logic [AW-1:0] early_addr;
  always_comb begin
    early_st = ST_OK;
    early_addr = idx_r[AW-1:0];
    if (!enabled_r || kind_r > K_RELTASK) early_st = ST_BAD_ARG;
    else begin
      unique case (kind_r)
        K_ALLOC: begin
          early_addr = free_idx;
          if (!cat_ok_alloc) early_st = ST_BAD_ARG;
          else if (!free_found) early_st = ST_NONE_FREE;
        end
        K_REG: begin
          if (!in_range) early_st = ST_BAD_ARG;
          else if (eff_map[idx_r[AW-1:0]]) early_st = ST_ALREADY;
        end
        K_FREE: begin
          if (!in_range) early_st = ST_BAD_ARG;
          else if (!eff_map[idx_r[AW-1:0]]) early_st = ST_NOT_ALLOC;
          else if (res_valid && idx_r[AW-1:0] == res_idx) early_st = ST_RESERVED;
        end
        K_ACQ, K_REL: begin
          if (!in_range) early_st = ST_BAD_ARG;
          else if (!eff_map[idx_r[AW-1:0]]) early_st = ST_NOT_ALLOC;
        end
        K_READ: if (!in_range) early_st = ST_BAD_ARG;
        K_CNTCAT: if ({28'd0, cat_r} >= NUM_CATEGORIES) early_st = ST_BAD_ARG;
        K_CNTALL: early_st = ST_OK;
        K_RELTASK: if (task_r == 32'd0) early_st = ST_BAD_ARG;
        default: early_st = ST_BAD_ARG;
      endcase
    end
  end

  // Result registers.
  logic [2:0]  st_r;
  logic [4:0]  gl_r;
  logic        oalloc_r;
  entry_t      oent_r;
  logic        out_valid_r;

  // Entry as a read returns it: the reserved entry shows the scheduler category.
  entry_t rd_ent;
  always_comb begin
    rd_ent = ram_rdata;
    if (cur_res) rd_ent.category = CAT_SCHED;
  end

  logic scan_kind;
  assign scan_kind = (kind_r == K_CNTCAT) || (kind_r == K_CNTALL) || (kind_r == K_RELTASK);
  logic last_addr;
  assign last_addr = ({{(32-AW){1'b0}}, addr_r} == 32'(NUM_LOCKS - 1));

  logic [63:0] held;
  assign held = ts_r - ram_rdata.last_acquire;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (AW+1)'(NUM_LOCKS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_RD;
      S_RD: begin
        if (early_st != ST_OK) state_nxt = S_OUT;
        else if (scan_kind) state_nxt = S_SCAN;
        else if (rd_wait_r) state_nxt = S_WB;
      end
      S_SCAN: if (rd_wait_r && last_addr) state_nxt = S_OUT;
      S_WB:   state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control and datapath outputs.
  always_comb begin
    ram_we      = 1'b0;
    ram_addr    = addr_r;
    ram_wdata   = ram_rdata;
    map_nxt     = map_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;
    rd_wait_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r[AW-1:0];
        ram_wdata = '0;
      end
      S_IDLE: begin
        addr_nxt = '0;
        cnt_nxt  = '0;
      end
      S_RD: begin
        ram_addr = early_addr;
        addr_nxt = early_addr;
        rd_wait_nxt = !rd_wait_r;
        if (scan_kind) begin
          ram_addr = '0;
          addr_nxt = '0;
        end
      end
      S_SCAN: begin
        // Data for addr_r arrives in the cycle after it is presented. A cleared
        // ownership uses the port for the write, so the next read goes out
        // after the write.
        if (rd_wait_r) begin
          if (cur_alloc) begin
            if (kind_r == K_CNTALL) cnt_nxt = cnt_r + 6'd1;
            else if (kind_r == K_CNTCAT) begin
              if ((cur_res ? CAT_SCHED : ram_rdata.category) == cat_r) cnt_nxt = cnt_r + 6'd1;
            end else if (ram_rdata.owner == task_r) begin
              cnt_nxt = cnt_r + 6'd1;
              ram_we = 1'b1;
              ram_wdata.owner = 32'd0;
            end
          end
          if (!last_addr) addr_nxt = addr_r + AW'(1);
          if (!ram_we) ram_addr = addr_nxt;
          rd_wait_nxt = !ram_we && !last_addr;
        end else begin
          rd_wait_nxt = 1'b1;
        end
      end
      S_WB: begin
        unique case (kind_r)
          K_ALLOC, K_REG: begin
            ram_we = 1'b1;
            ram_wdata.category = cat_r;
            ram_wdata.owner = '0;
            ram_wdata.acquires = '0;
            ram_wdata.total_held = '0;
            ram_wdata.max_held = '0;
            map_nxt[addr_r] = 1'b1;
          end
          K_FREE: begin
            ram_we = 1'b1;
            ram_wdata.category = '0;
            ram_wdata.owner = '0;
            map_nxt[addr_r] = 1'b0;
          end
          K_ACQ: begin
            ram_we = 1'b1;
            ram_wdata.last_acquire = ts_r;
            ram_wdata.owner = task_r;
            ram_wdata.acquires = ram_rdata.acquires + 32'd1;
          end
          K_REL: begin
            ram_we = 1'b1;
            ram_wdata.total_held = ram_rdata.total_held + held;
            if (held > ram_rdata.max_held) ram_wdata.max_held = held;
          end
          default: ram_we = 1'b0;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      map_r       <= '0;
      cnt_r       <= '0;
      addr_r      <= '0;
      rd_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      map_r     <= map_nxt;
      addr_r    <= addr_nxt;
      cnt_r     <= cnt_nxt;
      rd_wait_r <= rd_wait_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + (AW+1)'(1);
      if (state_nxt == S_OUT && state_r != S_OUT) out_valid_r <= 1'b1;
      else if (state_r == S_OUT && out_ready) out_valid_r <= 1'b0;
    end
  end

  // Request capture and result assembly.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      kind_r <= in_kind;
      idx_r  <= in_lock_index;
      cat_r  <= in_category_in;
      task_r <= in_task_id;
      ts_r   <= in_timestamp_us;
    end
    if (state_r == S_RD) begin
      st_r     <= early_st;
      gl_r     <= (kind_r == K_ALLOC && enabled_r)
                  ? ((early_st == ST_OK) ? 5'(early_addr) : 5'd0)
                  : idx_r[4:0];
      if (early_st == ST_OK && kind_r == K_READ && rd_wait_r) begin
        oalloc_r <= cur_alloc;
        oent_r   <= rd_ent;
      end else begin
        oalloc_r <= 1'b0;
        oent_r   <= '0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = st_r;
  assign out_granted_lock = gl_r;
  assign out_count_out = (st_r == ST_OK && scan_kind) ? cnt_r : 6'd0;
  assign out_entry_allocated = oalloc_r;
  assign out_entry_category = oent_r.category;
  assign out_entry_owner = oent_r.owner;
  assign out_entry_acquires = oent_r.acquires;
  assign out_entry_total_held = oent_r.total_held;
  assign out_entry_max_held = oent_r.max_held;
  assign out_entry_last_acquire = oent_r.last_acquire;

  `LA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "ready while busy")
  `LA_ASSERT_IMP(a_out_in_out, clk, rst_n, out_valid, state_r == S_OUT, "result outside output state")
  `LA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped")
endmodule

// ----- rtl/lahs_entry_ram.sv -----
// Single-port synchronous entry memory with registered read data.
module lahs_entry_ram import lahs_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  entry_t        wdata,
  output entry_t        rdata
);
  entry_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
